// ===== design/bbvp_pkg.sv =====
// Shared types, constants and codes for the basic block vector profiler.
package bbvp_pkg;

  localparam int NUM_BLOCKS_DEF  = 256;
  localparam int NUM_REGIONS_DEF = 64;

  localparam logic [47:0] THRESH_RESET = 48'd100000000;
  localparam logic [47:0] CTR_MAX      = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ACT_EVENT      = 3'd0,
    ACT_BEGIN      = 3'd1,
    ACT_END        = 3'd2,
    ACT_READ_ENTRY = 3'd3,
    ACT_READ_TOTAL = 3'd4
  } action_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] block_insts;
    logic [7:0]  block_id;
    logic [5:0]  read_region;
  } in_item_t;

  typedef struct packed {
    logic        region_closed;
    logic [5:0]  closed_region;
    logic [47:0] region_total;
    logic [31:0] entry_count;
    logic [47:0] entry_stamp;
    logic [6:0]  regions_used;
    logic        overflow;
  } out_item_t;

  // One block entry of a region bank.
  typedef struct packed {
    logic [31:0] count;
    logic [47:0] stamp;
  } entry_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic load;    // input transfer: capture item, issue memory reads
    logic commit;  // apply updates, fill the output register
    logic clear;   // write one zero entry of the clearing pass
  } ctl_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_sts_t;

endpackage

// ===== design/basic_block_vector_profiler.sv =====
// Top level of the basic block vector profiler.
//
//   port group  dir  handshake           payload
//   in_*        in   in_valid/in_ready   in_data   (bbvp_pkg::in_item_t)
//   out_*       out  out_valid/out_ready out_data  (bbvp_pkg::out_item_t)
//   cfg_*       in   cfg_we              cfg_wdata (region threshold, 48 bits)
//
// For each item the transfer cycle issues the memory reads; the commit then does the
// read-modify-write of the block entry and loads the result register.
// After reset a clearing pass zeroes all NUM_REGIONS * NUM_BLOCKS entries of the
// entry memory (16384 by default); no input transfer is taken during it.
// A new item is taken while an earlier result waits; its commit holds until the
// result register is free.
module basic_block_vector_profiler #(
  parameter int NUM_BLOCKS  = bbvp_pkg::NUM_BLOCKS_DEF,
  parameter int NUM_REGIONS = bbvp_pkg::NUM_REGIONS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [47:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  bbvp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bbvp_pkg::out_item_t out_data
);

  import bbvp_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  bbvp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bbvp_dpath #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .NUM_REGIONS (NUM_REGIONS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== design/bbvp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bbvp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/bbvp_ctrl.sv =====
// Controller: clearing pass, input transfer, commit and output valid.
module bbvp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  bbvp_pkg::dp_sts_t  sts,
  output bbvp_pkg::ctl_cmd_t cmd
);

  import bbvp_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (sts.clear_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC:  if (slot_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_CLEAR: cmd.clear = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_EXEC:  cmd.commit = slot_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== design/bbvp_dpath.sv =====
// Datapath: profile state, entry and region total memories, result register.
module bbvp_dpath #(
  parameter int NUM_BLOCKS  = bbvp_pkg::NUM_BLOCKS_DEF,
  parameter int NUM_REGIONS = bbvp_pkg::NUM_REGIONS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [47:0]         cfg_wdata,
  input  bbvp_pkg::in_item_t  in_data,
  output bbvp_pkg::out_item_t out_data,
  input  bbvp_pkg::ctl_cmd_t  cmd,
  output bbvp_pkg::dp_sts_t   sts
);

  import bbvp_pkg::*;

  localparam int EDEPTH = NUM_REGIONS * NUM_BLOCKS;
  localparam int EA_W   = $clog2(EDEPTH);
  localparam int RA_W   = $clog2(NUM_REGIONS);
  localparam int RI_W   = $clog2(NUM_REGIONS + 1);
  localparam int SEL_W  = (RI_W > 6) ? RI_W : 6;

  logic [47:0]     thr_r;
  logic            active_r, active_nxt;
  logic [47:0]     ctr_r, ctr_nxt;
  logic [RI_W-1:0] ridx_r, ridx_nxt;
  logic            ovf_r, ovf_nxt;
  in_item_t        in_r;
  logic [EA_W-1:0] eaddr_r, eaddr_nxt;
  logic [EA_W-1:0] clr_addr_r;
  out_item_t       out_r, out_nxt;

  logic [SEL_W-1:0] bank_sel;
  logic             full, bid_ok, rreg_ok, rreg_written;
  logic [48:0]      sum;
  logic [47:0]      ctr_sum;
  logic             close;
  logic [47:0]      close_total;
  logic             ent_upd;
  entry_t           ent_rd, ent_wr, ent_mem_wdata;
  logic [47:0]      tot_rd;
  logic             ent_we;
  logic [EA_W-1:0]  ent_waddr;

  // Entry address: bank times block count plus block id.
  always_comb begin
    if (in_data.action == ACT_EVENT) begin
      bank_sel = SEL_W'(ridx_r);
    end else begin
      bank_sel = SEL_W'(in_data.read_region);
    end
    eaddr_nxt = EA_W'(EA_W'(bank_sel) * EA_W'(NUM_BLOCKS) + EA_W'(in_data.block_id));
  end

  assign full         = (ridx_r == RI_W'(NUM_REGIONS));
  assign bid_ok       = 32'(in_r.block_id) < NUM_BLOCKS;
  assign rreg_ok      = 32'(in_r.read_region) < NUM_REGIONS;
  assign rreg_written = SEL_W'(in_r.read_region) < SEL_W'(ridx_r);
  assign sum          = {1'b0, ctr_r} + 49'(in_r.block_insts);
  assign ctr_sum      = sum[48] ? CTR_MAX : sum[47:0];

  always_comb begin
    active_nxt  = active_r;
    ctr_nxt     = ctr_r;
    ovf_nxt     = ovf_r;
    close       = 1'b0;
    close_total = '0;
    ent_upd     = 1'b0;
    out_nxt     = '0;
    unique case (in_r.action)
      ACT_EVENT: begin
        if (active_r) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else if (bid_ok) begin
            ent_upd = 1'b1;
            ctr_nxt = ctr_sum;
            if (ctr_sum > thr_r) begin
              close       = 1'b1;
              close_total = ctr_sum;
            end
          end
        end
      end
      ACT_BEGIN: active_nxt = 1'b1;
      ACT_END: begin
        if (active_r) begin
          active_nxt = 1'b0;
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            close       = 1'b1;
            close_total = ctr_r;
          end
        end
      end
      ACT_READ_ENTRY: begin
        if (rreg_ok && bid_ok) begin
          out_nxt.entry_count = ent_rd.count;
          out_nxt.entry_stamp = ent_rd.stamp;
        end
      end
      ACT_READ_TOTAL: begin
        // banks at or past the fill count have never been written
        if (rreg_ok && rreg_written) begin
          out_nxt.region_total = tot_rd;
        end
      end
      default: ;
    endcase

    ridx_nxt = ridx_r;
    if (close) begin
      ridx_nxt              = ridx_r + 1'b1;
      ctr_nxt               = '0;
      out_nxt.region_closed = 1'b1;
      out_nxt.closed_region = 6'(ridx_r);
      out_nxt.region_total  = close_total;
    end
    out_nxt.regions_used = 7'(ridx_nxt);
    out_nxt.overflow     = ovf_nxt;
  end

  always_comb begin
    ent_wr.count = (ent_rd.count == COUNT_MAX) ? COUNT_MAX : ent_rd.count + 32'd1;
    ent_wr.stamp = ctr_sum;
  end

  // Clearing pass owns the entry write port until it finishes.
  assign ent_we        = cmd.clear || (cmd.commit && ent_upd);
  assign ent_waddr     = cmd.clear ? clr_addr_r : eaddr_r;
  assign ent_mem_wdata = cmd.clear ? '0 : ent_wr;

  bbvp_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (EDEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_mem_wdata),
    .re    (cmd.load),
    .raddr (eaddr_nxt),
    .rdata (ent_rd)
  );

  bbvp_ram #(
    .WIDTH (48),
    .DEPTH (NUM_REGIONS)
  ) u_total_ram (
    .clk   (clk),
    .we    (cmd.commit && close),
    .waddr (RA_W'(ridx_r)),
    .wdata (close_total),
    .re    (cmd.load),
    .raddr (RA_W'(in_data.read_region)),
    .rdata (tot_rd)
  );

  assign sts.clear_last = (clr_addr_r == EA_W'(EDEPTH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= THRESH_RESET;
      active_r   <= 1'b0;
      ctr_r      <= '0;
      ridx_r     <= '0;
      ovf_r      <= 1'b0;
      clr_addr_r <= '0;
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      if (cmd.clear) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (cmd.commit) begin
        active_r <= active_nxt;
        ctr_r    <= ctr_nxt;
        ridx_r   <= ridx_nxt;
        ovf_r    <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r    <= in_data;
      eaddr_r <= eaddr_nxt;
    end
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule
